/* sv/lgd_pkg.sv */
`default_nettype none

package lgd_pkg;

  // APB register map: one 32-bit register per word
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic REG_THRESHOLD    = 1'b0;
  localparam logic REG_SAMPLE_WIDTH = 1'b1;

  localparam logic [31:0] THRESHOLD_RESET    = 32'd10;
  localparam logic [31:0] SAMPLE_WIDTH_RESET = 32'd500000;

  // input item modes
  localparam logic MODE_OPEN = 1'b0;
  localparam logic MODE_PAIR = 1'b1;

  // ns -> us conversion: floor(x / 1000) = floor((x >> 3) / 125)
  localparam logic [63:0] US_SAT_NS = 64'd4294967296000;  // 1000 * 2^32
  localparam logic [32:0] US_RECIP  = 33'd4398046511;     // floor(2^39 / 125)
  localparam logic [38:0] DIV_ODD   = 39'd125;
  localparam logic [31:0] US_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    STATUS_NONE      = 2'd0,
    STATUS_LATENCY   = 2'd1,
    STATUS_BACKWARDS = 2'd2
  } lgd_status_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] first_time_ns;
    logic [63:0] second_time_ns;
  } lgd_in_t;

  typedef struct packed {
    lgd_status_t status;
    logic [31:0] sequence_number;
    logic [31:0] inner_gap_us;
    logic [31:0] outer_gap_us;
    logic [31:0] peak_latency_us;
  } lgd_out_t;

  // per-stage load enables of the conversion pipeline
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } lgd_adv_t;

endpackage

`default_nettype wire

/* sv/latency_gap_detector_top.sv */
// A result passes the difference register, the three-stage ns-to-us reciprocal pipeline
//   and the window update into the output register. Throughput: one item per cycle; the
//   input only stalls when every stage is occupied and the output register is blocked.
// Reset (rst_n low, synchronous) empties the pipeline, closes the window, clears all
//   maxima and counts, and sets threshold_us to 10 and sample_width_us to 500000.
`default_nettype none

module latency_gap_detector_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire lgd_pkg::lgd_in_t                    in_data,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output lgd_pkg::lgd_out_t                        out_data,
  // APB configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lgd_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready
);

  // sideband that travels with each item down the pipeline
  typedef struct packed {
    logic mode;
    logic pair_prev;   // a previous t2 exists for the outer gap
    logic inner_neg;   // t2 - t1 negative
    logic outer_neg;   // t1 - previous t2 negative
  } lgd_tag_t;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [31:0] threshold_r;
  logic [31:0] sample_width_r;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= lgd_pkg::THRESHOLD_RESET;
      sample_width_r <= lgd_pkg::SAMPLE_WIDTH_RESET;
    end else if (cfg_write) begin
      unique case (paddr[lgd_pkg::APB_ADDR_W-1])
        lgd_pkg::REG_THRESHOLD:    threshold_r    <= pwdata;
        lgd_pkg::REG_SAMPLE_WIDTH: sample_width_r <= pwdata;
        default:                   threshold_r    <= threshold_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[lgd_pkg::APB_ADDR_W-1])
      lgd_pkg::REG_THRESHOLD:    prdata = threshold_r;
      lgd_pkg::REG_SAMPLE_WIDTH: prdata = sample_width_r;
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Pipeline flow control
  // A stage holds when it is full and the stage after it holds; the
  // last stage holds only while the output register is full and not
  // taken. Bubbles collapse, so input keeps flowing while a result waits.
  // ---------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic hold1, hold2, hold3, hold4;
  logic in_xfer;
  logic fire;
  logic out_valid_r;
  lgd_pkg::lgd_adv_t adv;

  assign hold4    = v4_r && out_valid_r && !out_ready;
  assign hold3    = v3_r && hold4;
  assign hold2    = v2_r && hold3;
  assign hold1    = v1_r && hold2;
  assign in_ready = !hold1;
  assign in_xfer  = in_valid && in_ready;
  assign fire     = v4_r && !hold4;   // item in last stage updates window state

  assign adv.s2 = !hold2;
  assign adv.s3 = !hold3;
  assign adv.s4 = !hold4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (!hold1) v1_r <= in_valid;
      if (!hold2) v2_r <= v1_r;
      if (!hold3) v3_r <= v2_r;
      if (!hold4) v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------
  // Front: time differences taken at transfer time.
  // Window start and previous t2 only depend on the order of items,
  // not on window state, so they are tracked here at the input.
  // A pair arriving with the window closed may update them freely:
  // the next open clears the previous-t2 flag anyway.
  // ---------------------------------------------------------------
  logic [63:0] start_ns_r;
  logic [63:0] prev_t2_r;
  logic        prev_valid_r;

  logic [63:0] d_inner;
  logic [63:0] d_outer;
  logic [63:0] d_total;

  assign d_inner = in_data.second_time_ns - in_data.first_time_ns;
  assign d_outer = in_data.first_time_ns - prev_t2_r;
  assign d_total = in_data.second_time_ns - start_ns_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_ns_r   <= '0;
      prev_t2_r    <= '0;
      prev_valid_r <= 1'b0;
    end else if (in_xfer) begin
      if (in_data.mode == lgd_pkg::MODE_OPEN) begin
        start_ns_r   <= in_data.first_time_ns;
        prev_valid_r <= 1'b0;
      end else begin
        prev_t2_r    <= in_data.second_time_ns;
        prev_valid_r <= 1'b1;
      end
    end
  end

  // stage 1: registered differences and sideband
  lgd_tag_t    tag1_r, tag2_r, tag3_r, tag4_r;
  logic [63:0] d_inner_r;
  logic [63:0] d_outer_r;
  logic [63:0] d_total_r;

  always_ff @(posedge clk) begin
    if (!hold1) begin
      tag1_r.mode      <= in_data.mode;
      tag1_r.pair_prev <= prev_valid_r;
      tag1_r.inner_neg <= d_inner[63];
      tag1_r.outer_neg <= d_outer[63];
      d_inner_r        <= d_inner;
      d_outer_r        <= d_outer;
      d_total_r        <= d_total;
    end
    if (!hold2) tag2_r <= tag1_r;
    if (!hold3) tag3_r <= tag2_r;
    if (!hold4) tag4_r <= tag3_r;
  end

  // stages 2..4: ns -> us conversion, one unit per difference
  logic [31:0] gap_in_us;
  logic [31:0] gap_out_us;
  logic [31:0] gap_tot_us;

  lgd_us_div u_div_inner (
    .clk     (clk),
    .adv     (adv),
    .diff_ns (d_inner_r),
    .gap_us  (gap_in_us)
  );

  lgd_us_div u_div_outer (
    .clk     (clk),
    .adv     (adv),
    .diff_ns (d_outer_r),
    .gap_us  (gap_out_us)
  );

  lgd_us_div u_div_total (
    .clk     (clk),
    .adv     (adv),
    .diff_ns (d_total_r),
    .gap_us  (gap_tot_us)
  );

  // ---------------------------------------------------------------
  // Window update: everything in microseconds from here on
  // ---------------------------------------------------------------
  logic        active_r;
  logic [31:0] prev_total_r;
  logic [31:0] inner_max_r;
  logic [31:0] outer_max_r;
  logic [31:0] det_count_r;
  logic [31:0] peak_r;

  logic        active_nxt;
  logic [31:0] prev_total_nxt;
  logic [31:0] inner_max_nxt;
  logic [31:0] outer_max_nxt;
  logic [31:0] det_count_nxt;
  logic [31:0] peak_nxt;

  logic                 emit;
  logic                 win_close;
  logic [31:0]          inner_cand;   // window maxima as reported
  logic [31:0]          outer_cand;
  lgd_pkg::lgd_status_t status_nxt;
  logic [31:0]          seq_nxt;

  always_comb begin
    active_nxt     = active_r;
    prev_total_nxt = prev_total_r;
    inner_max_nxt  = inner_max_r;
    outer_max_nxt  = outer_max_r;
    det_count_nxt  = det_count_r;
    peak_nxt       = peak_r;
    emit           = 1'b0;
    win_close      = 1'b0;
    inner_cand     = inner_max_r;
    outer_cand     = outer_max_r;
    status_nxt     = lgd_pkg::STATUS_NONE;
    seq_nxt        = '0;

    if (tag4_r.mode == lgd_pkg::MODE_OPEN) begin
      // open or restart: fresh window
      active_nxt     = 1'b1;
      prev_total_nxt = '0;
      inner_max_nxt  = '0;
      outer_max_nxt  = '0;
    end else if (active_r) begin
      if (tag4_r.pair_prev && tag4_r.outer_neg) begin
        // t1 before previous t2
        active_nxt = 1'b0;
        emit       = 1'b1;
        status_nxt = lgd_pkg::STATUS_BACKWARDS;
      end else begin
        if (tag4_r.pair_prev && (gap_out_us > outer_max_r)) begin
          outer_cand = gap_out_us;
        end
        outer_max_nxt = outer_cand;
        if (gap_tot_us < prev_total_r) begin
          // elapsed time went backwards: close without this inner gap
          win_close = 1'b1;
        end else begin
          prev_total_nxt = gap_tot_us;
          if (tag4_r.inner_neg) begin
            active_nxt = 1'b0;
            emit       = 1'b1;
            status_nxt = lgd_pkg::STATUS_BACKWARDS;
          end else begin
            if (gap_in_us > inner_max_r) begin
              inner_cand = gap_in_us;
            end
            inner_max_nxt = inner_cand;
            if (gap_tot_us > sample_width_r) begin
              win_close = 1'b1;
            end
          end
        end
      end
    end

    if (win_close) begin
      active_nxt = 1'b0;
      emit       = 1'b1;
      if ((inner_cand > threshold_r) || (outer_cand > threshold_r)) begin
        if (det_count_r != lgd_pkg::US_MAX) begin
          det_count_nxt = det_count_r + 32'd1;
        end
        if (inner_cand > peak_r) begin
          peak_nxt = inner_cand;
        end
        status_nxt = lgd_pkg::STATUS_LATENCY;
        seq_nxt    = det_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      prev_total_r <= '0;
      inner_max_r  <= '0;
      outer_max_r  <= '0;
      det_count_r  <= '0;
      peak_r       <= '0;
    end else if (fire) begin
      active_r     <= active_nxt;
      prev_total_r <= prev_total_nxt;
      inner_max_r  <= inner_max_nxt;
      outer_max_r  <= outer_max_nxt;
      det_count_r  <= det_count_nxt;
      peak_r       <= peak_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Output register: loads only when empty or being taken (fire
  // already guarantees that), drops when the transfer completes.
  // ---------------------------------------------------------------
  lgd_pkg::lgd_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_data_r.status          <= status_nxt;
      out_data_r.sequence_number <= seq_nxt;
      out_data_r.inner_gap_us    <= inner_cand;
      out_data_r.outer_gap_us    <= outer_cand;
      out_data_r.peak_latency_us <= peak_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_open_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (tag4_r.mode == lgd_pkg::MODE_OPEN)) |=>
      (active_r && (prev_total_r == '0) && (inner_max_r == '0) && (outer_max_r == '0)))
    else $error("window open did not reset window state");

  a_seq_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == lgd_pkg::STATUS_LATENCY)) |->
      ((out_data_r.sequence_number == det_count_r) && (det_count_r != '0)))
    else $error("latency result sequence number does not match detection count");

  a_seq_zero_otherwise: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != lgd_pkg::STATUS_LATENCY)) |->
      (out_data_r.sequence_number == '0))
    else $error("non-latency result carries a sequence number");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (peak_r >= $past(peak_r)))
    else $error("peak latency decreased");

  a_peak_reported: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.peak_latency_us == peak_r))
    else $error("pending result peak differs from peak register");

endmodule

`default_nettype wire

/* sv/lgd_us_div.sv */
`default_nettype none

// ns -> us, truncated and saturated at 32 bits; three stages.
// s2: split reciprocal multiply, s3: sum of partial products,
// s4: one-step remainder correction and saturation.
module lgd_us_div (
  input  wire logic             clk,
  input  wire lgd_pkg::lgd_adv_t adv,
  input  wire logic [63:0]      diff_ns,
  output logic      [31:0]      gap_us
);

  logic        sat2_r;
  logic [38:0] y2_r;
  logic [51:0] pph_r;
  logic [52:0] ppl_r;

  logic        sat3_r;
  logic [38:0] y3_r;
  logic [31:0] q0_r;

  logic [31:0] us_r;

  logic [71:0] sum3;
  logic [38:0] back4;
  logic [38:0] rem4;
  logic [31:0] q4;

  assign sum3  = {pph_r, 20'd0} + 72'(ppl_r);
  // 125 * q0 as shifts and adds
  assign back4 = {q0_r, 7'd0} - {5'd0, q0_r, 2'd0} + {7'd0, q0_r};
  assign rem4  = y3_r - back4;
  assign q4    = q0_r + 32'(rem4 >= lgd_pkg::DIV_ODD);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      sat2_r <= (diff_ns >= lgd_pkg::US_SAT_NS);
      y2_r   <= diff_ns[41:3];
      pph_r  <= 52'(diff_ns[41:23]) * 52'(lgd_pkg::US_RECIP);
      ppl_r  <= 53'(diff_ns[22:3]) * 53'(lgd_pkg::US_RECIP);
    end
    if (adv.s3) begin
      sat3_r <= sat2_r;
      y3_r   <= y2_r;
      q0_r   <= sum3[70:39];  // estimate, low by at most one
    end
    if (adv.s4) begin
      us_r <= sat3_r ? lgd_pkg::US_MAX : q4;
    end
  end

  assign gap_us = us_r;

endmodule

`default_nettype wire
